// ----- rtl/adtb_pkg.sv -----
// Package for the ASCII decimal to binary converter: widths, ASCII codes
// and the four-digit group helper. No dependencies.
package adtb_pkg;

    localparam int TEXT_W     = 64;   // one half of the text window
    localparam int MAX_DIGITS = 16;
    localparam int VALUE_W    = 54;
    localparam int COUNT_W    = 5;
    localparam int NIB_W      = 4 * MAX_DIGITS;
    localparam int GROUP_W    = 14;   // up to 9999
    localparam int HALF_W     = 27;   // up to 99999999
    localparam int NUM_GROUPS = MAX_DIGITS / 4;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    localparam logic [HALF_W-1:0]  GROUP_SCALE = HALF_W'(10000);
    localparam logic [VALUE_W-1:0] HALF_SCALE  = VALUE_W'(100000000);

    typedef logic [GROUP_W-1:0] t_group;
    typedef logic [HALF_W-1:0]  t_half;

    // Four BCD nibbles, most significant first, to their binary value.
    function automatic t_group bcd4_to_bin(input logic [15:0] nibs);
        t_group acc;
        acc = GROUP_W'(nibs[15:12]) * GROUP_W'(1000)
            + GROUP_W'(nibs[11:8])  * GROUP_W'(100)
            + GROUP_W'(nibs[7:4])   * GROUP_W'(10)
            + GROUP_W'(nibs[3:0]);
        return acc;
    endfunction

endpackage

// ----- rtl/ascii_decimal_to_binary.sv -----
// ASCII decimal to binary converter, top level.
// Depends on adtb_pkg (widths, ASCII codes, BCD group helper).
//
// Takes a window of up to 16 characters (character 0 in bits 63..56 of
// i_text_first_bytes) and returns the value and count of the leading ASCII
// digits; characters at DIGIT_WINDOW and beyond are ignored. One item is
// accepted per cycle while o_ready is high, and its result shows on o_valid
// after passing through five registers: input register, leading-digit mask
// and count, right-justify shift with four-digit groups, two eight-digit
// halves, and the final 27x27 constant multiply-add into the output register.
// o_ready falls only while the output register is held and every stage behind
// it is full.
module ascii_decimal_to_binary #(
    parameter int DIGIT_WINDOW = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [adtb_pkg::TEXT_W-1:0]     i_text_first_bytes,
    input  logic [adtb_pkg::TEXT_W-1:0]     i_text_last_bytes,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [adtb_pkg::VALUE_W-1:0]    o_number_value,
    output logic [adtb_pkg::COUNT_W-1:0]    o_digit_count
);

    localparam int ND = adtb_pkg::MAX_DIGITS;

    // stage valids and enables
    logic r_v1, r_v2, r_v3, r_v4, r_o_valid;
    logic en1, en2, en3, en4, en_o;

    logic [2*adtb_pkg::TEXT_W-1:0] r_text;
    logic [adtb_pkg::NIB_W-1:0]    r_nib;
    logic [adtb_pkg::COUNT_W-1:0]  r_cnt2, r_cnt3, r_cnt4, r_o_count;
    adtb_pkg::t_group              r_grp [adtb_pkg::NUM_GROUPS];
    adtb_pkg::t_half               r_hi, r_lo;
    logic [adtb_pkg::VALUE_W-1:0]  r_o_value;

    logic [adtb_pkg::NIB_W-1:0]    n_nib;
    logic [adtb_pkg::COUNT_W-1:0]  n_cnt2;
    adtb_pkg::t_group              n_grp [adtb_pkg::NUM_GROUPS];
    adtb_pkg::t_half               n_hi, n_lo;
    logic [adtb_pkg::VALUE_W-1:0]  n_o_value;

    logic [ND-1:0]                 is_dig, lead;
    logic [adtb_pkg::NIB_W-1:0]    shifted;
    logic [6:0]                    shamt;

    assign en_o    = !r_o_valid || i_ready;
    assign en4     = !r_v4 || en_o;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // leading-digit mask: bit i set when characters 0..i are all digits
    always_comb begin
        logic [7:0]    ch;
        logic [ND-1:0] low_mask;
        for (int i = 0; i < ND; i++) begin
            ch = r_text[2*adtb_pkg::TEXT_W-1-8*i -: 8];
            is_dig[i] = (ch >= adtb_pkg::ASCII_ZERO) && (ch <= adtb_pkg::ASCII_NINE)
                        && (i < DIGIT_WINDOW);
        end
        for (int i = 0; i < ND; i++) begin
            low_mask = ND'((32'd1 << (i + 1)) - 32'd1);
            lead[i]  = ((is_dig & low_mask) == low_mask);
        end
        for (int i = 0; i < ND; i++) begin
            ch = r_text[2*adtb_pkg::TEXT_W-1-8*i -: 8];
            n_nib[adtb_pkg::NIB_W-1-4*i -: 4] = lead[i] ? ch[3:0] : 4'd0;
        end
        n_cnt2 = adtb_pkg::COUNT_W'($countones(lead));
    end

    // right-justify the digits, then form four-digit groups
    always_comb begin
        shamt   = 7'(adtb_pkg::NIB_W) - {r_cnt2, 2'b00};
        shifted = r_nib >> shamt;
        for (int k = 0; k < adtb_pkg::NUM_GROUPS; k++) begin
            n_grp[k] = adtb_pkg::bcd4_to_bin(shifted[16*k +: 16]);
        end
    end

    assign n_hi = adtb_pkg::HALF_W'(r_grp[3]) * adtb_pkg::GROUP_SCALE
                + adtb_pkg::HALF_W'(r_grp[2]);
    assign n_lo = adtb_pkg::HALF_W'(r_grp[1]) * adtb_pkg::GROUP_SCALE
                + adtb_pkg::HALF_W'(r_grp[0]);
    assign n_o_value = adtb_pkg::VALUE_W'(r_hi) * adtb_pkg::HALF_SCALE
                     + adtb_pkg::VALUE_W'(r_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en1) r_v1      <= i_valid;
            if (en2) r_v2      <= r_v1;
            if (en3) r_v3      <= r_v2;
            if (en4) r_v4      <= r_v3;
            if (en_o) r_o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_text <= {i_text_first_bytes, i_text_last_bytes};
        end
        if (en2) begin
            r_nib  <= n_nib;
            r_cnt2 <= n_cnt2;
        end
        if (en3) begin
            r_grp  <= n_grp;
            r_cnt3 <= r_cnt2;
        end
        if (en4) begin
            r_hi   <= n_hi;
            r_lo   <= n_lo;
            r_cnt4 <= r_cnt3;
        end
        if (en_o) begin
            r_o_value <= n_o_value;
            r_o_count <= r_cnt4;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_number_value = r_o_value;
    assign o_digit_count  = r_o_count;

`ifndef SYNTHESIS
    // an empty output register lets the whole pipe advance
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output register");

    a_no_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_digit_count == '0) |-> (o_number_value == '0))
        else $error("nonzero value without digits");

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_digit_count) <= DIGIT_WINDOW))
        else $error("digit count beyond window");

    a_full_pipe_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_ready) |-> (o_valid && !i_ready))
        else $error("input stalled while output moves");
`endif

endmodule
